// ----- hdl/dmeq_pkg.sv -----
// Package for the delayed message expiry queue.
// Holds the entry type, status codes and the per-tick release limit.
// No dependencies.
package dmeq_pkg;

  typedef struct packed {
    logic [31:0] expiry;
    logic [7:0]  receiver;
    logic [15:0] handle;
  } entry_t;

  localparam logic [1:0] ST_RELEASED = 2'd0;
  localparam logic [1:0] ST_STORED   = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;

  localparam int MAX_RESULTS = 16;

endpackage

// ----- hdl/dmeq_ram.sv -----
// Generic simple dual-port RAM with registered read.
// One write port, one read port; no dependencies.
module dmeq_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/delayed_message_expiry_queue.sv -----
// Delayed message expiry queue: sorted queue of messages in a circular RAM.
// Depends on dmeq_pkg and dmeq_ram.
// Enqueue: dropped the cycle after start when full; else inserted in expiry order, shifting later entries up.
// Tick: scans from the head and stops at the first not-yet-due entry; due entries are released, at most 16.
// One item at a time, results strobed on out_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the queue and clears the tick count; RAM is not cleared.
module delayed_message_expiry_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [31:0] in_delay_ticks,
  input  logic [7:0]  in_receiver_id,
  input  logic [15:0] in_message_handle,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_receiver,
  output logic [15:0] out_handle,
  output logic [31:0] out_expiry,
  output logic        out_last
);
  import dmeq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ERD  = 6'b000010,
    S_ECMP = 6'b000100,
    S_TRD  = 6'b001000,
    S_TCMP = 6'b010000,
    S_TFIN = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [31:0]     count_r, count_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   occ_r, occ_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  entry_t          new_r, new_nxt;
  entry_t          pend_r, pend_nxt;
  logic            pend_v_r, pend_v_nxt;

  logic            ov_r, ov_nxt;
  logic [1:0]      ost_r, ost_nxt;
  entry_t          oent_r, oent_nxt;
  logic            olast_r, olast_nxt;

  logic [CW-1:0]   lidx;
  logic [SW-1:0]   psum;
  logic [AW-1:0]   paddr;
  logic            we;
  entry_t          wdata, rdata;

  always_comb begin
    psum = SW'(head_r) + SW'(lidx);
    if (psum >= SW'(DEPTH)) begin
      psum = psum - SW'(DEPTH);
    end
    paddr = psum[AW-1:0];
  end

  dmeq_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (paddr),
    .wdata (wdata),
    .raddr (paddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    new_nxt    = new_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ost_r;
    oent_nxt   = oent_r;
    olast_nxt  = olast_r;
    lidx       = idx_r;
    we         = 1'b0;
    wdata      = new_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!in_operation) begin
            new_nxt.expiry   = count_r + in_delay_ticks;
            new_nxt.receiver = in_receiver_id;
            new_nxt.handle   = in_message_handle;
            if (occ_r == CW'(DEPTH)) begin
              ov_nxt    = 1'b1;
              ost_nxt   = ST_DROPPED;
              oent_nxt  = new_nxt;
              olast_nxt = 1'b1;
            end else begin
              idx_nxt   = occ_r;
              state_nxt = S_ERD;
            end
          end else begin
            count_nxt  = count_r + 32'd1;
            idx_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_TRD;
          end
        end
      end
      S_ERD: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          ov_nxt    = 1'b1;
          ost_nxt   = ST_STORED;
          oent_nxt  = new_r;
          olast_nxt = 1'b1;
          occ_nxt   = occ_r + CW'(1);
          state_nxt = S_IDLE;
        end else begin
          lidx      = idx_r - CW'(1);
          state_nxt = S_ECMP;
        end
      end
      S_ECMP: begin
        we = 1'b1;
        if (rdata.expiry >= new_r.expiry) begin
          wdata     = rdata;
          idx_nxt   = idx_r - CW'(1);
          state_nxt = S_ERD;
        end else begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_STORED;
          oent_nxt  = new_r;
          olast_nxt = 1'b1;
          occ_nxt   = occ_r + CW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_TRD: begin
        if ((idx_r < occ_r) && (32'(idx_r) < MAX_RESULTS)) begin
          state_nxt = S_TCMP;
        end else begin
          state_nxt = S_TFIN;
        end
      end
      S_TCMP: begin
        if (rdata.expiry <= count_r) begin
          if (pend_v_r) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_RELEASED;
            oent_nxt  = pend_r;
            olast_nxt = 1'b0;
          end
          pend_nxt   = rdata;
          pend_v_nxt = 1'b1;
          idx_nxt    = idx_r + CW'(1);
          state_nxt  = S_TRD;
        end else begin
          state_nxt = S_TFIN;
        end
      end
      S_TFIN: begin
        if (pend_v_r) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_RELEASED;
          oent_nxt  = pend_r;
          olast_nxt = 1'b1;
        end
        pend_v_nxt = 1'b0;
        head_nxt   = paddr;
        occ_nxt    = occ_r - idx_r;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      head_r   <= '0;
      occ_r    <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      head_r   <= head_nxt;
      occ_r    <= occ_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    new_r   <= new_nxt;
    pend_r  <= pend_nxt;
    ost_r   <= ost_nxt;
    oent_r  <= oent_nxt;
    olast_r <= olast_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = ov_r;
  assign out_status   = ost_r;
  assign out_receiver = oent_r.receiver;
  assign out_handle   = oent_r.handle;
  assign out_expiry   = oent_r.expiry;
  assign out_last     = olast_r;

endmodule

// ----- hdl/dmeq_chk.sv -----
// Port-level checker for the delayed message expiry queue, with its bind.
// Depends on dmeq_pkg for the status codes.
module dmeq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic        out_last
);
  import dmeq_pkg::*;

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither busy nor answered");

  a_enq_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_RELEASED) |-> out_last)
    else $error("enqueue result not marked last");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_RELEASED || out_status == ST_STORED ||
                   out_status == ST_DROPPED))
    else $error("bad status code");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> busy)
    else $error("release burst ended without last");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("not idle after reset");

endmodule

bind delayed_message_expiry_queue dmeq_chk u_dmeq_chk (.*);

// ----- dv/tb.sv -----
// Testbench for delayed_message_expiry_queue: random and directed enqueue and tick items.
// Predicts results with a sorted queue model and checks them in order.
// Depends on dmeq_pkg and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmeq_pkg::*;

  localparam int DEPTH = 16;
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] delay;
    logic [7:0]  rcv;
    logic [15:0] hnd;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  rcv;
    logic [15:0] hnd;
    logic [31:0] expiry;
    logic        last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = 1'b0;
  logic [31:0] in_delay_ticks = '0;
  logic [7:0] in_receiver_id = '0;
  logic [15:0] in_message_handle = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [7:0] out_receiver;
  logic [15:0] out_handle;
  logic [31:0] out_expiry;
  logic out_last;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  entry_t timer_queue[$];
  logic [31:0] now_ticks = '0;
  int gap_left = 0;
  bit failed = 0;
  bit stim_done = 0;

  delayed_message_expiry_queue #(.DEPTH(DEPTH)) u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_results(cmd_t c);
    entry_t e;
    res_t r;
    int pos;
    int n;
    if (c.op == OP_ENQUEUE) begin
      e.expiry = now_ticks + c.delay;
      e.receiver = c.rcv;
      e.handle = c.hnd;
      r = res_t'{ST_STORED, c.rcv, c.hnd, e.expiry, 1'b1};
      if (timer_queue.size() >= DEPTH) begin
        r.status = ST_DROPPED;
      end else begin
        pos = 0;
        while (pos < timer_queue.size() && timer_queue[pos].expiry < e.expiry) pos++;
        timer_queue.insert(pos, e);
      end
      expected_results.push_back(r);
    end else begin
      now_ticks = now_ticks + 1;
      n = 0;
      while (n < MAX_RESULTS && timer_queue.size() > 0 && timer_queue[0].expiry <= now_ticks) begin
        e = timer_queue.pop_front();
        expected_results.push_back(res_t'{ST_RELEASED, e.receiver, e.handle, e.expiry, 1'b0});
        n++;
      end
      if (n > 0) expected_results[expected_results.size()-1].last = 1'b1;
    end
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_results(cmd_t'{in_operation, in_delay_ticks, in_receiver_id, in_message_handle});
        gap_left <= pick_gap();
        if (pending_cmds.size() > 0 && pick_gap() == 0 && gap_left == 0) begin
          in_operation <= pending_cmds[0].op;
          in_delay_ticks <= pending_cmds[0].delay;
          in_receiver_id <= pending_cmds[0].rcv;
          in_message_handle <= pending_cmds[0].hnd;
          void'(pending_cmds.pop_front());
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0) begin
          start <= 1'b1;
          in_operation <= pending_cmds[0].op;
          in_delay_ticks <= pending_cmds[0].delay;
          in_receiver_id <= pending_cmds[0].rcv;
          in_message_handle <= pending_cmds[0].hnd;
          void'(pending_cmds.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result status=%0d handle=%h", out_status, out_handle);
        failed = 1;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, out_status);
          failed = 1;
        end
        if (out_receiver !== exp_r.rcv) begin
          $error("out_receiver: expected %h actual %h", exp_r.rcv, out_receiver);
          failed = 1;
        end
        if (out_handle !== exp_r.hnd) begin
          $error("out_handle: expected %h actual %h", exp_r.hnd, out_handle);
          failed = 1;
        end
        if (out_expiry !== exp_r.expiry) begin
          $error("out_expiry: expected %h actual %h", exp_r.expiry, out_expiry);
          failed = 1;
        end
        if (out_last !== exp_r.last) begin
          $error("last: expected %0d actual %0d", exp_r.last, out_last);
          failed = 1;
        end
      end
    end
  end

  function automatic cmd_t enq(logic [31:0] d);
    return cmd_t'{OP_ENQUEUE, d, 8'($urandom), 16'($urandom)};
  endfunction

  function automatic cmd_t tick_cmd();
    return cmd_t'{OP_TICK, $urandom, 8'($urandom), 16'($urandom)};
  endfunction

  initial begin
    int i;
    int k;
    int burst;
    pending_cmds.push_back(cmd_t'{OP_ENQUEUE, 32'd0, 8'h00, 16'h0000});
    pending_cmds.push_back(cmd_t'{OP_ENQUEUE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF});
    pending_cmds.push_back(cmd_t'{OP_ENQUEUE, 32'd2, 8'hA5, 16'h5A5A});
    pending_cmds.push_back(cmd_t'{OP_ENQUEUE, 32'd2, 8'h5A, 16'hA5A5});
    pending_cmds.push_back(tick_cmd());
    pending_cmds.push_back(tick_cmd());
    pending_cmds.push_back(tick_cmd());
    for (i = 0; i < 17; i++) pending_cmds.push_back(enq(32'd1 + (i % 3)));
    pending_cmds.push_back(tick_cmd());
    pending_cmds.push_back(tick_cmd());
    pending_cmds.push_back(tick_cmd());
    i = 0;
    while (i < 60) begin
      burst = $urandom_range(1, 8);
      for (k = 0; k < burst; k++) begin
        case ($urandom_range(0, 9))
          0: pending_cmds.push_back(enq($urandom));
          1: pending_cmds.push_back(enq(32'hFFFF_FFF0 + $urandom_range(0, 15)));
          default: pending_cmds.push_back(enq($urandom_range(0, 6)));
        endcase
        i++;
      end
      burst = $urandom_range(0, 5);
      for (k = 0; k < burst; k++) begin
        pending_cmds.push_back(tick_cmd());
        i++;
      end
    end
    for (i = 0; i < 10; i++) pending_cmds.push_back(tick_cmd());
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/dmeq_pkg.sv
hdl/dmeq_ram.sv
hdl/delayed_message_expiry_queue.sv
hdl/dmeq_chk.sv
dv/tb.sv
